// File: rtl/spo2_ratio_of_ratios_estimator_macros.svh
// Assertion macros shared by the estimator RTL.
`ifndef SPO2_RATIO_OF_RATIOS_ESTIMATOR_MACROS_SVH
`define SPO2_RATIO_OF_RATIOS_ESTIMATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define SPO2_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spo2 check failed");
// Next-cycle implication, disabled in reset.
`define SPO2_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spo2 next-cycle check failed");
`else
`define SPO2_CHECK(lbl, ante, cons)
`define SPO2_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/spo2_pkg.sv
// Package: widths, codes, coefficients and types of the SpO2 estimator.
`timescale 1ns / 1ps
package spo2_pkg;

  localparam int SAMPLE_BITS = 18;
  localparam int MAX_WINDOW  = 1024;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int LOG_WIN     = $clog2(MAX_WINDOW);
  localparam int SUM_W       = SAMPLE_BITS + LOG_WIN;
  localparam int SQ_W        = 2 * SAMPLE_BITS + LOG_WIN;
  localparam int DC_W        = 18;
  localparam int WLEN_W      = 11;
  localparam int FLOOR_W     = DC_W + CNT_W;
  localparam int VAR_W       = CNT_W + SQ_W;
  localparam int S2_W        = 2 * SUM_W;
  localparam int MUL_W       = (VAR_W > S2_W) ? VAR_W : S2_W;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MCNT_W      = $clog2(MUL_W + 1);
  localparam int DEN_W       = VAR_W + S2_W;
  localparam int R_BITS      = 20;
  localparam int X_W         = 2 * R_BITS;
  localparam int FRAC_SHIFT  = 32;
  localparam int DROP        = X_W - FRAC_SHIFT;
  localparam int RT_W        = R_BITS + 2;
  localparam int STEP_W      = $clog2(X_W + 1);
  localparam int PCT_W       = 7;
  localparam int STAT_W      = 2;
  localparam int IDX_W       = 2;
  localparam int CFG_W       = 18;

  localparam int K2_W = 22;
  localparam int K1_W = 21;
  localparam int K0_W = 23;
  localparam int KT_W = K2_W + X_W;
  localparam int KU_W = K1_W + R_BITS;
  localparam int P_W  = 64;
  localparam logic [K2_W-1:0] K2_Q16 = 22'd2953052;
  localparam logic [K1_W-1:0] K1_Q16 = 21'd1989280;
  localparam logic [K0_W-1:0] K0_Q16 = 23'd6215762;
  localparam logic [P_W-1:0]  P_LOW  = 64'd50 << 48;
  localparam logic [P_W-1:0]  P_HIGH = 64'd100 << 48;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd400;
  localparam logic [DC_W-1:0]   DC_RESET   = 18'd5000;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;

  typedef enum logic [IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_MIN_DC     = 2'd1
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_LOW       = 2'd1,
    STATUS_NO_FINGER = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQUARE, ST_ACCUM, ST_FLOOR, ST_RED_NSQ, ST_RED_S2,
    ST_IR_NSQ, ST_IR_S2, ST_RHS, ST_DEN, ST_SATCHK, ST_DIV, ST_ROOT,
    ST_Q2, ST_K2, ST_K1, ST_POLY, ST_RESULT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// File: rtl/spo2_if.sv
// Interfaces: sample input, result output and configuration write channels.
`timescale 1ns / 1ps
interface spo2_in_if import spo2_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red_sample;
  logic [SAMPLE_BITS-1:0] ir_sample;
  modport source (output valid, red_sample, ir_sample, input ready);
  modport sink   (input valid, red_sample, ir_sample, output ready);
endinterface

interface spo2_out_if import spo2_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PCT_W-1:0]  spo2_pct;
  logic              window_done;
  logic [STAT_W-1:0] status;
  modport source (output valid, spo2_pct, window_done, status, input ready);
  modport sink   (input valid, spo2_pct, window_done, status, output ready);
endinterface

interface spo2_cfg_if import spo2_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/spo2_mul.sv
// Bit-serial shift-add multiplier shared by the window computation.
`timescale 1ns / 1ps
module spo2_mul import spo2_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod,
  output mul_stat_t         stat
);

  logic [MUL_W-1:0]  areg;
  logic [MUL_W-1:0]  hi;
  logic [MUL_W-1:0]  lo;
  logic [MCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [MUL_W:0]    sum;

  // one multiplier bit per cycle, LSB first
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= MCNT_W'(MUL_W);
      end else if (busy) begin
        cnt <= cnt - MCNT_W'(1);
        if (cnt == MCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      hi   <= '0;
      lo   <= b;
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
  end

  assign prod = {hi, lo};
  assign stat = '{busy: busy, done: done};

endmodule

// File: rtl/spo2_ratio_of_ratios_estimator.sv
// Top level: ratio-of-ratios SpO2 estimator over windows of red/IR sample pairs.
`timescale 1ns / 1ps
`include "spo2_ratio_of_ratios_estimator_macros.svh"
// Takes one red/IR sample pair per transaction and returns one result transaction
// for each pair, carrying the latest SpO2 estimate, its status, and a flag that
// marks the pair that closed a window. One pair is processed at a time. Both
// samples of a pair are squared bit-serially before the sums are updated. The
// pair that closes a window also takes up to ten passes through the shared
// 57-bit bit-serial multiplier, and may need a restoring divider and a 20-step
// square root. The result sits in an output register, so a waiting sink does
// not hold back the start of the next pair. Registers: index 0 is the window
// length (clamped to 2..1024 when used), index 1 the DC floor that both
// channel means must exceed. Writes take effect at once.
module spo2_ratio_of_ratios_estimator import spo2_pkg::*; (
  input logic        clk,
  input logic        rst,
  spo2_in_if.sink    samples,
  spo2_out_if.source results,
  spo2_cfg_if.sink   cfg
);

  state_t state, state_next;

  // configuration
  logic [WLEN_W-1:0] window_len;
  logic [DC_W-1:0]   min_dc;
  logic [CNT_W-1:0]  win_eff;

  // running window state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [SUM_W-1:0] red_sum, ir_sum;
  logic [SQ_W-1:0]  red_sq_sum, ir_sq_sum;
  logic [PCT_W-1:0] last_est;
  status_t          last_status;
  logic             win_flag;

  // per-sample squaring
  logic [SAMPLE_BITS-1:0] red_a, ir_a, red_hi, red_lo, ir_hi, ir_lo;
  logic [SAMPLE_BITS:0]   red_add, ir_add;
  logic [STEP_W-1:0]      step;

  // window datapath
  logic [VAR_W-1:0]  vr, vi, vi_new;
  logic [S2_W-1:0]   sr2, si2, s2_now;
  logic [PROD_W-1:0] big;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    div_sh, div_diff;
  logic              div_ge;
  logic [X_W-1:0]    dq, xq;
  logic [RT_W-1:0]   rt_rem;
  logic [RT_W+1:0]   rt_sh, rt_trial, rt_diff;
  logic              rt_ge;
  logic [R_BITS-1:0] q;
  logic [X_W-1:0]    q2;
  logic [KT_W-1:0]   kt;
  logic [KU_W-1:0]   ku;
  logic [P_W-1:0]    poly;
  logic              sat;
  logic [FLOOR_W-1:0] floor_v;
  logic               no_finger;

  // multiplier
  logic              launch;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  mul_stat_t         mul_stat;

  // output register
  logic              out_valid;
  logic [PCT_W-1:0]  out_pct;
  logic              out_done;
  logic [STAT_W-1:0] out_status;

  function automatic logic is_mul(state_t s);
    return s inside {ST_FLOOR, ST_RED_NSQ, ST_RED_S2, ST_IR_NSQ, ST_IR_S2,
                     ST_RHS, ST_DEN, ST_Q2, ST_K2, ST_K1};
  endfunction

  spo2_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (launch),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .stat  (mul_stat)
  );

  assign samples.ready       = (state == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign results.valid       = out_valid;
  assign results.spo2_pct    = out_pct;
  assign results.window_done = out_done;
  assign results.status      = out_status;

  // clamp the window length to the supported range
  always_comb begin
    if (window_len < WLEN_W'(2)) begin
      win_eff = CNT_W'(2);
    end else if (window_len > WLEN_W'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_len);
    end
  end

  assign count_inc = count + CNT_W'(1);
  assign red_add   = {1'b0, red_hi} + (red_lo[0] ? {1'b0, red_a} : '0);
  assign ir_add    = {1'b0, ir_hi} + (ir_lo[0] ? {1'b0, ir_a} : '0);
  assign floor_v   = prod[FLOOR_W-1:0];
  assign no_finger = (FLOOR_W'(red_sum) <= floor_v) || (FLOOR_W'(ir_sum) <= floor_v);
  assign s2_now    = prod[S2_W-1:0];
  assign vi_new    = (vi >= VAR_W'(s2_now)) ? vi - VAR_W'(s2_now) : '0;
  assign sat       = (big >> DROP) >= PROD_W'(den);

  // one quotient bit of the restoring divider
  assign div_sh   = {rem, dq[X_W-1]};
  assign div_ge   = div_sh >= {1'b0, den};
  assign div_diff = div_sh - {1'b0, den};

  // one root bit of the restoring square root
  assign rt_sh    = {rt_rem, xq[X_W-1:X_W-2]};
  assign rt_trial = (RT_W + 2)'({q, 2'b01});
  assign rt_ge    = rt_sh >= rt_trial;
  assign rt_diff  = rt_sh - rt_trial;

  // P = K0*2^32 + K1*Rq*2^16 - K2*Rq^2, all in Q48
  assign poly = (P_W'(K0_Q16) << FRAC_SHIFT) + (P_W'(ku) << 16) - P_W'(kt);

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FLOOR: begin
        mul_a = MUL_W'(min_dc);
        mul_b = MUL_W'(count);
      end
      ST_RED_NSQ: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(red_sq_sum);
      end
      ST_RED_S2: begin
        mul_a = MUL_W'(red_sum);
        mul_b = MUL_W'(red_sum);
      end
      ST_IR_NSQ: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(ir_sq_sum);
      end
      ST_IR_S2: begin
        mul_a = MUL_W'(ir_sum);
        mul_b = MUL_W'(ir_sum);
      end
      ST_RHS: begin
        mul_a = MUL_W'(vr);
        mul_b = MUL_W'(si2);
      end
      ST_DEN: begin
        mul_a = MUL_W'(vi);
        mul_b = MUL_W'(sr2);
      end
      ST_Q2: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(q);
      end
      ST_K2: begin
        mul_a = MUL_W'(K2_Q16);
        mul_b = MUL_W'(q2);
      end
      ST_K1: begin
        mul_a = MUL_W'(K1_Q16);
        mul_b = MUL_W'(q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (step == STEP_W'(1)) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = (count_inc >= win_eff) ? ST_FLOOR : ST_RESULT;
      end
      ST_FLOOR: begin
        if (mul_stat.done) begin
          state_next = no_finger ? ST_RESULT : ST_RED_NSQ;
        end
      end
      ST_RED_NSQ: if (mul_stat.done) state_next = ST_RED_S2;
      ST_RED_S2:  if (mul_stat.done) state_next = ST_IR_NSQ;
      ST_IR_NSQ:  if (mul_stat.done) state_next = ST_IR_S2;
      ST_IR_S2: begin
        if (mul_stat.done) begin
          state_next = (vi_new == '0) ? ST_RESULT : ST_RHS;
        end
      end
      ST_RHS: if (mul_stat.done) state_next = ST_DEN;
      ST_DEN: if (mul_stat.done) state_next = ST_SATCHK;
      ST_SATCHK: begin
        state_next = sat ? ST_Q2 : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(1)) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (step == STEP_W'(1)) begin
          state_next = ST_Q2;
        end
      end
      ST_Q2: if (mul_stat.done) state_next = ST_K2;
      ST_K2: if (mul_stat.done) state_next = ST_K1;
      ST_K1: if (mul_stat.done) state_next = ST_POLY;
      ST_POLY: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || results.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers: config, window state, estimate, output valid, step counter, multiplier launch
  always_ff @(posedge clk) begin
    if (rst) begin
      launch      <= 1'b0;
      window_len  <= WLEN_RESET;
      min_dc      <= DC_RESET;
      count       <= '0;
      red_sum     <= '0;
      ir_sum      <= '0;
      red_sq_sum  <= '0;
      ir_sq_sum   <= '0;
      last_est    <= '0;
      last_status <= STATUS_NO_FINGER;
      win_flag    <= 1'b0;
      out_valid   <= 1'b0;
      step        <= '0;
    end else begin
      launch <= is_mul(state_next) && (state_next != state);

      if (cfg.valid) begin
        case (cfg_idx_t'(cfg.index))
          CFG_WINDOW_LEN: window_len <= cfg.data[WLEN_W-1:0];
          CFG_MIN_DC:     min_dc     <= cfg.data[DC_W-1:0];
          default: begin
          end
        endcase
      end

      // load a new result when the register is free or being taken, else drop it once taken
      if ((state == ST_RESULT) && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          step <= STEP_W'(SAMPLE_BITS);
        end
        ST_SQUARE: begin
          step <= step - STEP_W'(1);
        end
        ST_ACCUM: begin
          // fold the pair into the window
          count      <= count_inc;
          red_sum    <= red_sum + SUM_W'(red_a);
          ir_sum     <= ir_sum + SUM_W'(ir_a);
          red_sq_sum <= red_sq_sum + SQ_W'({red_hi, red_lo});
          ir_sq_sum  <= ir_sq_sum + SQ_W'({ir_hi, ir_lo});
          win_flag   <= (count_inc >= win_eff);
        end
        ST_FLOOR: begin
          if (mul_stat.done && no_finger) begin
            last_est    <= '0;
            last_status <= STATUS_NO_FINGER;
          end
        end
        ST_IR_S2: begin
          if (mul_stat.done && (vi_new == '0)) begin
            last_est    <= '0;
            last_status <= STATUS_LOW;
          end
        end
        ST_SATCHK: begin
          step <= STEP_W'(X_W);
        end
        ST_DIV: begin
          step <= (step == STEP_W'(1)) ? STEP_W'(R_BITS) : step - STEP_W'(1);
        end
        ST_ROOT: begin
          step <= step - STEP_W'(1);
        end
        ST_POLY: begin
          if ($signed(poly) < $signed(P_LOW)) begin
            last_est    <= '0;
            last_status <= STATUS_LOW;
          end else if ($signed(poly) > $signed(P_HIGH)) begin
            last_est    <= PCT_MAX;
            last_status <= STATUS_VALID;
          end else begin
            last_est    <= poly[48 +: PCT_W];
            last_status <= STATUS_VALID;
          end
        end
        ST_RESULT: begin
          // drop the window once its estimate is settled
          if (win_flag) begin
            count      <= '0;
            red_sum    <= '0;
            ir_sum     <= '0;
            red_sq_sum <= '0;
            ir_sq_sum  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          red_a  <= samples.red_sample;
          ir_a   <= samples.ir_sample;
          red_lo <= samples.red_sample;
          ir_lo  <= samples.ir_sample;
          red_hi <= '0;
          ir_hi  <= '0;
        end
      end
      ST_SQUARE: begin
        red_hi <= red_add[SAMPLE_BITS:1];
        red_lo <= {red_add[0], red_lo[SAMPLE_BITS-1:1]};
        ir_hi  <= ir_add[SAMPLE_BITS:1];
        ir_lo  <= {ir_add[0], ir_lo[SAMPLE_BITS-1:1]};
      end
      ST_RED_NSQ: if (mul_stat.done) vr <= prod[VAR_W-1:0];
      ST_RED_S2: begin
        if (mul_stat.done) begin
          sr2 <= s2_now;
          vr  <= (vr >= VAR_W'(s2_now)) ? vr - VAR_W'(s2_now) : '0;
        end
      end
      ST_IR_NSQ: if (mul_stat.done) vi <= prod[VAR_W-1:0];
      ST_IR_S2: begin
        if (mul_stat.done) begin
          si2 <= s2_now;
          vi  <= vi_new;
        end
      end
      ST_RHS: if (mul_stat.done) big <= prod;
      ST_DEN: if (mul_stat.done) den <= prod[DEN_W-1:0];
      ST_SATCHK: begin
        // the quotient would not fit: saturate R
        if (sat) begin
          q <= '1;
        end
        rem <= DEN_W'(big >> DROP);
        dq  <= {big[DROP-1:0], {FRAC_SHIFT{1'b0}}};
      end
      ST_DIV: begin
        rem    <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
        dq     <= {dq[X_W-2:0], 1'b0};
        xq     <= {xq[X_W-2:0], div_ge};
        rt_rem <= '0;
        q      <= '0;
      end
      ST_ROOT: begin
        rt_rem <= rt_ge ? rt_diff[RT_W-1:0] : rt_sh[RT_W-1:0];
        q      <= {q[R_BITS-2:0], rt_ge};
        xq     <= {xq[X_W-3:0], 2'b00};
      end
      ST_Q2: if (mul_stat.done) q2 <= prod[X_W-1:0];
      ST_K2: if (mul_stat.done) kt <= prod[KT_W-1:0];
      ST_K1: if (mul_stat.done) ku <= prod[KU_W-1:0];
      ST_RESULT: begin
        if (!out_valid || results.ready) begin
          out_pct    <= last_est;
          out_done   <= win_flag;
          out_status <= STAT_W'(last_status);
        end
      end
      default: begin
      end
    endcase
  end

  `SPO2_CHECK(a_launch_free, launch, !mul_stat.busy)
  `SPO2_CHECK(a_done_in_step, mul_stat.done, is_mul(state))
  `SPO2_CHECK(a_est_range, 1'b1, last_est <= PCT_MAX)
  `SPO2_CHECK(a_valid_plausible, last_status == STATUS_VALID, last_est >= PCT_W'(50))
  `SPO2_NEXT(a_window_clear, (state == ST_RESULT) && win_flag, count == '0)

endmodule

// File: test/spo2_ratio_of_ratios_estimator_test.sv
// Testbench for the ratio-of-ratios SpO2 estimator: directed and random sample windows.
`timescale 1ns / 1ps
module spo2_ratio_of_ratios_estimator_test;
  import spo2_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [PCT_W-1:0] pct;
    logic             done;
    status_t          stat;
  } spo2_result_t;

  logic clk;
  logic rst;

  spo2_in_if  in_ch ();
  spo2_out_if out_ch ();
  spo2_cfg_if cfg_ch ();

  spo2_ratio_of_ratios_estimator dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_ch.sink),
    .results (out_ch.source),
    .cfg     (cfg_ch.sink)
  );

  // Shadow of the block: registers and window accumulators.
  logic [WLEN_W-1:0] win_len_reg;
  logic [DC_W-1:0]   min_dc_reg;
  logic [10:0]       pair_count;
  logic [27:0]       red_acc;
  logic [27:0]       ir_acc;
  logic [45:0]       red_sq_acc;
  logic [45:0]       ir_sq_acc;
  logic [PCT_W-1:0]  held_pct;
  status_t           held_status;

  spo2_result_t pending_results[$];
  int           mismatches;
  int           cycles;
  int           hold_off_cycles;   // long receiver hold-off, counted by the sink process
  bit           no_idle;           // run both sides without gaps

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spo2_ratio_of_ratios_estimator test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // n * sum_sq - sum^2, clamped at zero.
  function automatic logic [255:0] spread(input logic [10:0] n, input logic [27:0] s,
                                          input logic [45:0] sq);
    logic [255:0] a;
    logic [255:0] b;
    a = 256'(n) * 256'(sq);
    b = 256'(s) * 256'(s);
    return (a < b) ? 256'd0 : a - b;
  endfunction

  // Decide on a completed window and update the held estimate.
  function automatic void close_window();
    logic [63:0]  dc_floor;
    logic [255:0] vr;
    logic [255:0] vi;
    logic [255:0] rhs;
    logic [255:0] den;
    logic [255:0] lhs;
    logic [19:0]  q;
    logic [19:0]  t;
    longint       rq;
    longint       p;
    dc_floor = 64'(min_dc_reg) * 64'(pair_count);
    if (64'(red_acc) <= dc_floor || 64'(ir_acc) <= dc_floor) begin
      held_pct    = '0;
      held_status = STATUS_NO_FINGER;
      return;
    end
    vr = spread(pair_count, red_acc, red_sq_acc);
    vi = spread(pair_count, ir_acc, ir_sq_acc);
    if (vi == 0) begin
      held_pct    = '0;
      held_status = STATUS_LOW;
      return;
    end
    rhs = (vr * (256'(ir_acc) * 256'(ir_acc))) << 32;
    den = vi * (256'(red_acc) * 256'(red_acc));
    q = '0;
    // Largest Q4.16 ratio whose square keeps lhs within rhs.
    for (int b = 19; b >= 0; b--) begin
      t = q | (20'd1 << b);
      lhs = den * (256'(t) * 256'(t));
      if (lhs <= rhs) q = t;
    end
    rq = longint'(q);
    p = 64'd6215762 * (64'd1 << 32) + 64'd1989280 * rq * 65536 - 64'd2953052 * rq * rq;
    if (p < (longint'(50) << 48)) begin
      held_pct    = '0;
      held_status = STATUS_LOW;
    end else if (p > (longint'(100) << 48)) begin
      held_pct    = PCT_MAX;
      held_status = STATUS_VALID;
    end else begin
      held_pct    = PCT_W'(p >>> 48);
      held_status = STATUS_VALID;
    end
  endfunction

  function automatic spo2_result_t estimate_step(input logic [17:0] r, input logic [17:0] x);
    spo2_result_t res;
    int           win;
    win = int'(win_len_reg);
    if (win < 2) win = 2;
    if (win > MAX_WINDOW) win = MAX_WINDOW;
    pair_count = pair_count + 11'd1;
    red_acc    = red_acc + 28'(r);
    ir_acc     = ir_acc + 28'(x);
    red_sq_acc = red_sq_acc + 46'(r) * 46'(r);
    ir_sq_acc  = ir_sq_acc + 46'(x) * 46'(x);
    res.done = 1'b0;
    if (int'(pair_count) >= win) begin
      close_window();
      pair_count = '0;
      red_acc    = '0;
      ir_acc     = '0;
      red_sq_acc = '0;
      ir_sq_acc  = '0;
      res.done   = 1'b1;
    end
    res.pct  = held_pct;
    res.stat = held_status;
    return res;
  endfunction

  // Offer one pair; record its expected result once the transaction completes.
  task automatic send_pair(input logic [17:0] r, input logic [17:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.red_sample <= r;
    in_ch.ir_sample  <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(estimate_step(r, x));
  endtask

  // Drop valid and hold until every expected result has arrived.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WINDOW_LEN) win_len_reg = value[WLEN_W-1:0];
    else min_dc_reg = value[DC_W-1:0];
  endtask

  // Receiver: random stalls, plus the long hold-off when requested.
  always @(posedge clk) begin : sink_stall
    int stall_left;
    int r;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (!no_idle && r < 20) stall_left = $urandom_range(1, 4);
      else if (!no_idle && r < 23) stall_left = $urandom_range(20, 80);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    spo2_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.spo2_pct !== want.pct || out_ch.window_done !== want.done ||
            out_ch.status !== want.stat) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: pct %0d/%0d done %0d/%0d status %0d/%0d (exp/act)",
                     want.pct, out_ch.spo2_pct, want.done, out_ch.window_done,
                     want.stat, out_ch.status);
        end
      end
    end
  end

  // Pulse-like pair around given DC levels with given swing.
  task automatic send_pulse(input int dc_r, input int amp_r, input int dc_i, input int amp_i);
    send_pair(18'(dc_r + $urandom_range(0, amp_r)), 18'(dc_i + $urandom_range(0, amp_i)));
  endtask

  task automatic test_reset_defaults();
    // Partial window under the reset length; fields at their extremes.
    send_pair(18'h0, 18'h3FFFF);
    send_pair(18'h3FFFF, 18'h0);
    send_pair(18'h2AAAA, 18'h15555);
  endtask

  task automatic test_special_windows();
    // Length 0 acts as 2: count is already past it, so the next pair closes.
    write_reg(CFG_WINDOW_LEN, 18'd0);
    send_pair(18'h3FFFF, 18'h3FFFF);
    write_reg(CFG_WINDOW_LEN, 18'd1);
    // Finger absent.
    send_pair(18'd10, 18'd20);
    send_pair(18'd30, 18'd40);
    // Flat IR: zero variance.
    send_pair(18'd100000, 18'd150000);
    send_pair(18'd120000, 18'd150000);
    // Well-formed pulse, moderate ratio.
    send_pair(18'd100000, 18'd120000);
    send_pair(18'd101000, 18'd122000);
    // Flat red: ratio zero, so the estimate is the constant term of the curve.
    send_pair(18'd100000, 18'd120000);
    send_pair(18'd100000, 18'd122000);
    // Tiny IR swing against a huge red one: ratio saturates, implausible.
    write_reg(CFG_MIN_DC, 18'd0);
    send_pair(18'd1000, 18'd200000);
    send_pair(18'h3FFFF, 18'd200001);
    write_reg(CFG_MIN_DC, 18'h3FFFF);
    send_pair(18'h3FFFF, 18'h3FFFF);
    send_pair(18'h3FFFE, 18'h3FFFF);
    write_reg(CFG_MIN_DC, 18'd5000);
  endtask

  task automatic test_window_clamp_high();
    // 2047 acts as the maximum; shorten it mid-window to close early.
    write_reg(CFG_WINDOW_LEN, 18'd2047);
    for (int k = 0; k < 12; k++) send_pulse(150000, 8000, 90000, 4000);
    write_reg(CFG_WINDOW_LEN, 18'd1024);
    for (int k = 0; k < 6; k++) send_pulse(150000, 8000, 90000, 4000);
    write_reg(CFG_WINDOW_LEN, 18'd3);
    send_pulse(150000, 8000, 90000, 4000);
  endtask

  task automatic test_hold_off();
    // Receiver holds off long while pairs keep coming, so the input stalls.
    write_reg(CFG_WINDOW_LEN, 18'd4);
    hold_off_cycles = 3000;
    for (int k = 0; k < 12; k++) send_pulse(60000, 3000, 70000, 3000);
    wait_idle();
  endtask

  task automatic test_random_windows();
    int pairs;
    int mode;
    int dc_r;
    int dc_i;
    int amp_r;
    int amp_i;
    int amp_lo;
    int win;
    pairs = 0;
    while (pairs < 700) begin
      // Mostly short windows; sometimes clamped or long ones cut short.
      mode = $urandom_range(0, 99);
      if (mode < 80) win = $urandom_range(2, 12);
      else if (mode < 90) win = $urandom_range(0, 1);
      else win = $urandom_range(13, 2047);
      write_reg(CFG_WINDOW_LEN, 18'(win));
      mode = $urandom_range(0, 9);
      if (mode == 0) write_reg(CFG_MIN_DC, 18'($urandom_range(0, 262143)));
      else if (mode < 8) write_reg(CFG_MIN_DC, 18'($urandom_range(0, 20000)));
      no_idle = ($urandom_range(0, 7) == 0);
      for (int w = 0; w < 4; w++) begin
        dc_r   = $urandom_range(20000, 200000);
        dc_i   = $urandom_range(20000, 200000);
        amp_r  = $urandom_range(1, dc_r / 8);
        // scale the IR swing by the DC ratio in 64 bits to avoid overflow
        amp_lo = int'(longint'(amp_r) * longint'(dc_i) / longint'(dc_r));
        amp_i  = $urandom_range(amp_lo / 3 + 1, amp_lo * 2 + 1);
        if (amp_i > 60000) amp_i = 60000;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < ((win < 2) ? 2 : (win > 12 ? 12 : win)); k++) begin
          if (mode < 7) send_pulse(dc_r, amp_r, dc_i, amp_i);
          else if (mode == 7) send_pair(18'($urandom_range(0, 3000)), 18'($urandom_range(0, 3000)));
          else send_pair(18'($urandom), 18'($urandom));
          pairs++;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst              = 1'b1;
    cycles           = 0;
    mismatches       = 0;
    hold_off_cycles  = 0;
    no_idle          = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.red_sample <= '0;
    in_ch.ir_sample  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_WINDOW_LEN;
    cfg_ch.data      <= '0;
    win_len_reg = WLEN_RESET;
    min_dc_reg  = DC_RESET;
    pair_count  = '0;
    red_acc     = '0;
    ir_acc      = '0;
    red_sq_acc  = '0;
    ir_sq_acc   = '0;
    held_pct    = '0;
    held_status = STATUS_NO_FINGER;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_special_windows();
    test_window_clamp_high();
    test_hold_off();
    test_random_windows();

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("spo2_ratio_of_ratios_estimator test passed");
    end else begin
      $display("spo2_ratio_of_ratios_estimator test failed");
    end
    $finish;
  end

endmodule
